FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker of the scanline IRQ block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, ignored while reset is held.
`define SLIRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle, ignored while reset is held.
`define SLIRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle, checked through reset as well.
`define SLIRQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/slirq_pkg.sv
// Package with the types, codes and constants of the scanline IRQ block.
`timescale 1ns / 1ps

package slirq_pkg;

    // Extension RAM size in bytes; must be a power of two.
    localparam int EXRAM_DEPTH = 1024;
    localparam int EXRAM_AW    = $clog2(EXRAM_DEPTH);

    localparam int OFFSET_W = 10;
    localparam int DATA_W   = 8;
    localparam int ACTION_W = 4;
    localparam int MODE_W   = 2;
    localparam int S_TDATA_W = 24;

    localparam logic [7:0] LINE_RESET   = 8'd240;
    localparam logic [7:0] PENDING_BIT  = 8'h80;
    localparam logic [7:0] FRAME_BIT    = 8'h40;
    localparam logic [7:0] OPEN_BUS_HI  = 8'h5C;
    localparam logic [MODE_W-1:0] MODE_READ_WRITE = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_MCAND  = 4'd0,
        ACT_WR_MPLIER = 4'd1,
        ACT_RD_PLO    = 4'd2,
        ACT_RD_PHI    = 4'd3,
        ACT_WR_LINE   = 4'd4,
        ACT_WR_CTRL   = 4'd5,
        ACT_RD_STATUS = 4'd6,
        ACT_WR_EXRAM  = 4'd7,
        ACT_RD_EXRAM  = 4'd8,
        ACT_SCANLINE  = 4'd9,
        ACT_VBLANK    = 4'd10
    } action_t;

    // One access to the extension RAM.
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [EXRAM_AW-1:0] addr;
        logic [DATA_W-1:0]   wdata;
    } exram_req_t;

    // Offsets wrap modulo the RAM depth.
    function automatic logic [EXRAM_AW-1:0] exram_slot(input logic [OFFSET_W-1:0] offset);
        logic [EXRAM_AW+OFFSET_W-1:0] wide;
        wide = {{EXRAM_AW{1'b0}}, offset};
        return wide[EXRAM_AW-1:0];
    endfunction

endpackage

FILE: hdl/slirq_exram.sv
// Extension RAM with a clearing sweep after reset and registered read data.
`timescale 1ns / 1ps

module slirq_exram (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  slirq_pkg::exram_req_t     req,
    output logic [slirq_pkg::DATA_W-1:0] rd_data,
    output logic                      busy
);
    import slirq_pkg::*;

    logic [DATA_W-1:0]   mem [EXRAM_DEPTH];
    logic                busy_reg;
    logic                busy_next;
    logic [EXRAM_AW-1:0] clr_addr_reg;
    logic [EXRAM_AW-1:0] clr_addr_next;
    logic [DATA_W-1:0]   rd_data_reg;

    always_comb begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == EXRAM_AW'(EXRAM_DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

FILE: hdl/scanline_irq_multiplier_exram_core.sv
// Top level: multiplier, scanline IRQ unit and extension RAM of a cartridge mapper.
`timescale 1ns / 1ps
// A result passes through the first-stage register and then the output register on the master side.
// Throughput: one transfer per cycle when not stalled; only RAM items use the single RAM port.
// Reset clears the state registers (the line counter loads LINE_RESET), not the payload;
// the RAM is then zeroed by a sweep of all EXRAM_DEPTH (1024) addresses, with s_tready low.

module scanline_irq_multiplier_exram_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: extension RAM mode.
    input  logic                              cfg_wen,
    input  logic [slirq_pkg::MODE_W-1:0]      cfg_wdata,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [slirq_pkg::S_TDATA_W-1:0]   s_tdata,  // [9:0] ram_offset, [17:10] data, zero pad
    input  logic [slirq_pkg::ACTION_W-1:0]    s_tuser,  // [3:0] action
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [slirq_pkg::DATA_W-1:0]      m_tdata,  // [7:0] read_data
    output logic                              m_tuser   // [0] irq_request
);
    import slirq_pkg::*;

    // Input fields of the transfer on the slave side.
    logic [OFFSET_W-1:0] in_offset;
    logic [DATA_W-1:0]   in_data;
    action_t             in_action;
    logic                accept;

    assign in_offset = s_tdata[OFFSET_W-1:0];
    assign in_data   = s_tdata[OFFSET_W +: DATA_W];
    assign in_action = action_t'(s_tuser);

    // Architectural state.
    logic [MODE_W-1:0] exram_mode_reg;
    logic [DATA_W-1:0] multiplicand_reg, multiplicand_next;
    logic [DATA_W-1:0] multiplier_reg, multiplier_next;
    logic [15:0]       product_reg, product_next;
    logic [7:0]        target_line_reg, target_line_next;
    logic              irq_enable_reg, irq_enable_next;
    logic              pending_reg, pending_next;
    logic              frame_reg, frame_next;
    logic [7:0]        line_counter_reg, line_counter_next;

    // First stage: the result of the accepted item, with RAM data arriving
    // from the RAM's output register in the cycle after the transfer.
    logic              a_valid_reg, a_valid_next;
    logic [DATA_W-1:0] a_rd_reg, a_rd_next;
    logic              a_irq_reg, a_irq_next;
    logic              a_ram_sel_reg, a_ram_sel_next;

    // Output register on the master side.
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_irq_reg;

    logic              b_free;
    logic              a_move;

    exram_req_t        ram_req;
    logic [DATA_W-1:0] ram_rd_data;
    logic              ram_busy;

    slirq_exram u_exram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (ram_rd_data),
        .busy    (ram_busy)
    );

    // The output register frees up when it is empty or being emptied; the
    // first stage can then pass its item on, so once the RAM sweep is done one transfer per
    // cycle flows, and a waiting result still leaves room for one more item.
    assign b_free   = !m_valid_reg || m_tready;
    assign a_move   = a_valid_reg && b_free;
    assign s_tready = !ram_busy && (!a_valid_reg || b_free);
    assign accept   = s_tvalid && s_tready;

    // Decode of one item: state updates and the result byte are decided here from the
    // incoming fields and the current state; only a RAM read byte is picked later.
    always_comb begin
        logic [7:0] line_inc;

        multiplicand_next = multiplicand_reg;
        multiplier_next   = multiplier_reg;
        product_next      = product_reg;
        target_line_next  = target_line_reg;
        irq_enable_next   = irq_enable_reg;
        pending_next      = pending_reg;
        frame_next        = frame_reg;
        line_counter_next = line_counter_reg;
        a_rd_next         = a_rd_reg;
        a_irq_next        = a_irq_reg;
        a_ram_sel_next    = a_ram_sel_reg;
        ram_req.wr_en     = 1'b0;
        ram_req.rd_en     = 1'b0;
        ram_req.addr      = exram_slot(in_offset);
        ram_req.wdata     = in_data;
        line_inc          = line_counter_reg + 8'd1;

        if (accept) begin
            a_rd_next      = '0;
            a_irq_next     = 1'b0;
            a_ram_sel_next = 1'b0;
            case (in_action)
                ACT_WR_MCAND: begin
                    multiplicand_next = in_data;
                    product_next      = 16'(in_data) * 16'(multiplier_reg);
                end
                ACT_WR_MPLIER: begin
                    multiplier_next = in_data;
                    product_next    = 16'(multiplicand_reg) * 16'(in_data);
                end
                ACT_RD_PLO: begin
                    a_rd_next = product_reg[7:0];
                end
                ACT_RD_PHI: begin
                    a_rd_next = product_reg[15:8];
                end
                ACT_WR_LINE: begin
                    target_line_next = in_data;
                end
                ACT_WR_CTRL: begin
                    irq_enable_next = in_data[7];
                end
                ACT_RD_STATUS: begin
                    a_rd_next    = (pending_reg ? PENDING_BIT : 8'h00)
                                 | (frame_reg ? FRAME_BIT : 8'h00);
                    pending_next = 1'b0;
                end
                ACT_WR_EXRAM: begin
                    ram_req.wr_en = (exram_mode_reg == MODE_READ_WRITE);
                end
                ACT_RD_EXRAM: begin
                    // With mode bit 1 clear the CPU sees the address high byte.
                    if (exram_mode_reg[1]) begin
                        ram_req.rd_en  = 1'b1;
                        a_ram_sel_next = 1'b1;
                    end else begin
                        a_rd_next = OPEN_BUS_HI + {6'd0, in_offset[9:8]};
                    end
                end
                ACT_SCANLINE: begin
                    frame_next        = 1'b1;
                    line_counter_next = line_inc;
                    if (line_inc == target_line_reg && target_line_reg != 8'd0) begin
                        pending_next = 1'b1;
                        a_irq_next   = irq_enable_reg;
                    end else begin
                        pending_next = 1'b0;
                    end
                end
                ACT_VBLANK: begin
                    frame_next        = 1'b0;
                    line_counter_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (a_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exram_mode_reg   <= '0;
            multiplicand_reg <= '0;
            multiplier_reg   <= '0;
            product_reg      <= '0;
            target_line_reg  <= '0;
            irq_enable_reg   <= 1'b0;
            pending_reg      <= 1'b0;
            frame_reg        <= 1'b0;
            line_counter_reg <= LINE_RESET;
            a_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                exram_mode_reg <= cfg_wdata;
            end
            multiplicand_reg <= multiplicand_next;
            multiplier_reg   <= multiplier_next;
            product_reg      <= product_next;
            target_line_reg  <= target_line_next;
            irq_enable_reg   <= irq_enable_next;
            pending_reg      <= pending_next;
            frame_reg        <= frame_next;
            line_counter_reg <= line_counter_next;
            a_valid_reg      <= a_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Result payload of both stages; the RAM byte is picked as the item moves on.
    always_ff @(posedge aclk) begin
        a_rd_reg      <= a_rd_next;
        a_irq_reg     <= a_irq_next;
        a_ram_sel_reg <= a_ram_sel_next;
        if (a_move) begin
            m_data_reg <= a_ram_sel_reg ? ram_rd_data : a_rd_reg;
            m_irq_reg  <= a_irq_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_irq_reg;

endmodule

FILE: hdl/slirq_checker.sv
// Port-level checker for the scanline IRQ block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slirq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [slirq_pkg::DATA_W-1:0]    m_tdata,
    input logic                            m_tuser
);
    import slirq_pkg::*;

    // A stalled result keeps its payload.
    `SLIRQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // An interrupt request only comes from a scanline tick, which returns no byte.
    `SLIRQ_ASSERT_NOW(a_irq_no_data, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    // Reset empties the result channel.
    `SLIRQ_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)
    // The RAM clearing sweep starts with reset, so no transfer is taken right after it.
    `SLIRQ_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !s_tready)

endmodule

bind scanline_irq_multiplier_exram_core slirq_checker u_slirq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/mapper_bus_checker.sv
// Checker that predicts every bus reply of the mapper core and compares it with the result channel.
`timescale 1ns / 1ps

module mapper_bus_checker
    import slirq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [MODE_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [ACTION_W-1:0]   s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_W-1:0]     m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_request;
    } bus_reply_t;

    // Shadow copy of the mapper state.
    logic [MODE_W-1:0] exram_mode_q;
    logic [7:0]        mcand_q;
    logic [7:0]        mplier_q;
    logic [15:0]       product_q;
    logic [7:0]        irq_target_q;
    logic              irq_en_q;
    logic              pending_q;
    logic              in_frame_q;
    logic [7:0]        line_cnt_q;
    logic [DATA_W-1:0] exram_shadow [EXRAM_DEPTH];

    bus_reply_t reply_q [$];

    function automatic bus_reply_t predict_reply(input logic [ACTION_W-1:0] act,
                                                 input logic [OFFSET_W-1:0] off,
                                                 input logic [DATA_W-1:0]   wdat);
        bus_reply_t          rep;
        logic [EXRAM_AW-1:0] slot;
        rep  = '0;
        slot = EXRAM_AW'(int'(off) % EXRAM_DEPTH);
        case (act)
            ACT_WR_MCAND: begin
                mcand_q   = wdat;
                product_q = 16'(mcand_q) * 16'(mplier_q);
            end
            ACT_WR_MPLIER: begin
                mplier_q  = wdat;
                product_q = 16'(mcand_q) * 16'(mplier_q);
            end
            ACT_RD_PLO:  rep.read_data = product_q[7:0];
            ACT_RD_PHI:  rep.read_data = product_q[15:8];
            ACT_WR_LINE: irq_target_q = wdat;
            // Only the top bit of the control byte is the enable.
            ACT_WR_CTRL: irq_en_q = wdat[7];
            ACT_RD_STATUS: begin
                rep.read_data = (pending_q ? PENDING_BIT : 8'h00) |
                                (in_frame_q ? FRAME_BIT : 8'h00);
                pending_q = 1'b0;
            end
            ACT_WR_EXRAM: begin
                if (exram_mode_q == MODE_READ_WRITE) begin
                    exram_shadow[slot] = wdat;
                end
            end
            ACT_RD_EXRAM: begin
                if (exram_mode_q[1]) begin
                    rep.read_data = exram_shadow[slot];
                end else begin
                    rep.read_data = OPEN_BUS_HI + {6'b000000, off[9:8]};
                end
            end
            ACT_SCANLINE: begin
                in_frame_q = 1'b1;
                line_cnt_q = line_cnt_q + 8'd1;
                if (line_cnt_q == irq_target_q && irq_target_q != 8'd0) begin
                    pending_q       = 1'b1;
                    rep.irq_request = irq_en_q;
                end else begin
                    pending_q = 1'b0;
                end
            end
            ACT_VBLANK: begin
                in_frame_q = 1'b0;
                line_cnt_q = 8'd0;
            end
            default: ;
        endcase
        return rep;
    endfunction

    always @(posedge aclk) begin
        bus_reply_t want;
        if (!aresetn) begin
            exram_mode_q = '0;
            mcand_q      = '0;
            mplier_q     = '0;
            product_q    = '0;
            irq_target_q = '0;
            irq_en_q     = 1'b0;
            pending_q    = 1'b0;
            in_frame_q   = 1'b0;
            line_cnt_q   = LINE_RESET;
            for (int i = 0; i < EXRAM_DEPTH; i++) begin
                exram_shadow[i] = '0;
            end
            reply_q.delete();
        end else begin
            if (cfg_wen) begin
                exram_mode_q = cfg_wdata;
            end
            // Retire the oldest reply before queueing a new one, so that a reply
            // appearing in the same cycle as its own request is still flagged.
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected result: read_data %02h, irq_request %0b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_tdata !== want.read_data) begin
                        $error("read_data: expected %02h, got %02h", want.read_data, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.irq_request) begin
                        $error("irq_request: expected %0b, got %0b", want.irq_request, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                reply_q.push_back(predict_reply(s_tuser, s_tdata[OFFSET_W-1:0],
                                                s_tdata[OFFSET_W +: DATA_W]));
            end
        end
        outstanding = reply_q.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: drives bus accesses and video events into the mapper core and reports the verdict.
`timescale 1ns / 1ps

module tb;
    import slirq_pkg::*;

    // Extension RAM modes besides the read-write one from the package.
    localparam logic [MODE_W-1:0] MODE_NAMETABLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ATTRIBUTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_ONLY = 2'd3;

    // Action codes the block does not decode; they must yield an all-zero reply.
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd11;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;

    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;
    // Items in the long frame with no vblank, more than the 256 values of the line counter.
    localparam int WRAP_LINES   = 262;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [MODE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACTION_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 m_tuser;

    int fail_count;
    int outstanding;

    // When set, the sender offers transfers back to back with no gaps.
    bit tight_burst = 1'b0;

    int unsigned cycle_count = 0;

    always #5 aclk = ~aclk;

    scanline_irq_multiplier_exram_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mapper_bus_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog: the run fails if it is still going at CYCLE_LIMIT, a bound that must cover
    // the slowest legal run, including the RAM clearing sweep after reset.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: before each transfer the receiver stalls for a random number
    // of cycles, with the odd stretch in which it accepts every result at once.
    initial begin
        int stall;
        int streak;
        streak = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (streak > 0) begin
                stall = 0;
                streak--;
            end else begin
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 9) == 0) begin
                    streak = $urandom_range(10, 40);
                end
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Offers one item and returns at the falling edge after its transfer. The
    // valid is only lowered when a gap is actually taken, so back-to-back
    // items keep it high without a glitch.
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [OFFSET_W-1:0] off,
                             input logic [DATA_W-1:0]   dat);
        int gap;
        gap = tight_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - OFFSET_W - DATA_W){1'b0}}, dat, off};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every predicted reply has been seen, then
    // lets the pipeline show any stray result.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
    endtask

    // The mode register is only ever written while the block is idle.
    task automatic set_exram_mode(input logic [MODE_W-1:0] mode);
        drain_replies();
        cfg_wen   <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    // Half the offsets are fully random; the rest fall on a small set of
    // slots, so that reads often find bytes written earlier in the run.
    function automatic logic [OFFSET_W-1:0] pick_offset();
        logic [1:0] top_bits;
        logic [3:0] low_bits;
        top_bits = 2'($urandom_range(0, 3));
        low_bits = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) begin
            return OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
        end
        return {top_bits, 4'b0000, low_bits};
    endfunction

    // One item of the random mix; scanline ticks dominate so that targets are reached.
    task automatic send_random_item();
        int                  roll;
        logic [ACTION_W-1:0] act;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            act = ACT_SCANLINE;
        end else if (roll < 33) begin
            act = ACT_VBLANK;
        end else if (roll < 38) begin
            act = ACT_WR_LINE;
        end else if (roll < 42) begin
            act = ACT_WR_CTRL;
        end else if (roll < 50) begin
            act = ACT_RD_STATUS;
        end else if (roll < 56) begin
            act = ACT_WR_MCAND;
        end else if (roll < 62) begin
            act = ACT_WR_MPLIER;
        end else if (roll < 66) begin
            act = ACT_RD_PLO;
        end else if (roll < 70) begin
            act = ACT_RD_PHI;
        end else if (roll < 81) begin
            act = ACT_WR_EXRAM;
        end else if (roll < 93) begin
            act = ACT_RD_EXRAM;
        end else if (roll < 97) begin
            act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end else begin
            act = ACTION_W'($urandom_range(0, (1 << ACTION_W) - 1));
        end
        // A target written at random would rarely be reached, so most are small.
        if (act == ACT_WR_LINE && $urandom_range(0, 3) != 0) begin
            send_item(act, pick_offset(), DATA_W'($urandom_range(1, 24)));
        end else begin
            send_item(act, pick_offset(), DATA_W'($urandom_range(0, 255)));
        end
    endtask

    // Random phase built from frames: most open with a vblank, a fresh target
    // and an enable setting, then run a random mix; the rest are bare noise.
    task automatic run_random_phase(input int n_items);
        int sent;
        int frame_len;
        sent = 0;
        while (sent < n_items) begin
            tight_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send_item(ACT_VBLANK, pick_offset(), DATA_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) == 0) begin
                    send_item(ACT_WR_LINE, pick_offset(), DATA_W'($urandom_range(0, 255)));
                end else begin
                    send_item(ACT_WR_LINE, pick_offset(), DATA_W'($urandom_range(1, 20)));
                end
                send_item(ACT_WR_CTRL, pick_offset(), DATA_W'($urandom_range(0, 255)));
                sent += 3;
            end
            frame_len = $urandom_range(8, 40);
            repeat (frame_len) send_random_item();
            sent += frame_len;
        end
        tight_burst = 1'b0;
    endtask

    // A long frame with no vblank: a target at the top or bottom of the counter's range, the
    // enable set, then WRAP_LINES items, mostly scanline ticks and about one in eight status reads.
    task automatic run_counter_wrap();
        if ($urandom_range(0, 1) == 0) begin
            send_item(ACT_WR_LINE, pick_offset(), DATA_W'($urandom_range(245, 255)));
        end else begin
            send_item(ACT_WR_LINE, pick_offset(), DATA_W'($urandom_range(1, 8)));
        end
        send_item(ACT_WR_CTRL, pick_offset(), 8'h80);
        repeat (WRAP_LINES) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(ACT_RD_STATUS, pick_offset(), DATA_W'($urandom_range(0, 255)));
            end else begin
                send_item(ACT_SCANLINE, pick_offset(), DATA_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [MODE_W-1:0] phase_mode [NUM_PHASES];
        phase_mode = '{MODE_READ_WRITE, MODE_READ_ONLY, MODE_NAMETABLE, MODE_ATTRIBUTE,
                       MODE_READ_WRITE, MODE_READ_ONLY, MODE_NAMETABLE, MODE_READ_WRITE};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The RAM is first filled at both ends of the offset range
        // and read back, then the multiplier is driven to its largest product.
        set_exram_mode(MODE_READ_WRITE);
        send_item(ACT_WR_EXRAM, 10'h000, 8'hA5);
        send_item(ACT_WR_EXRAM, 10'h3FF, 8'h5A);
        send_item(ACT_RD_EXRAM, 10'h000, 8'h00);
        send_item(ACT_RD_EXRAM, 10'h3FF, 8'hFF);
        send_item(ACT_WR_MCAND, 10'h3FF, 8'hFF);
        send_item(ACT_WR_MPLIER, 10'h000, 8'hFF);
        send_item(ACT_RD_PLO, 10'h000, 8'h00);
        send_item(ACT_RD_PHI, 10'h000, 8'h00);
        // Scanline interrupt: the second line after vblank matches the target,
        // and the status read shows pending once, then only in-frame.
        send_item(ACT_VBLANK, 10'h000, 8'h00);
        send_item(ACT_WR_LINE, 10'h000, 8'h02);
        send_item(ACT_WR_CTRL, 10'h000, 8'h80);
        send_item(ACT_SCANLINE, 10'h000, 8'h00);
        send_item(ACT_SCANLINE, 10'h000, 8'h00);
        send_item(ACT_RD_STATUS, 10'h000, 8'h00);
        send_item(ACT_RD_STATUS, 10'h000, 8'h00);
        // A target of zero never matches, whatever the counter holds.
        send_item(ACT_WR_LINE, 10'h000, 8'h00);
        send_item(ACT_SCANLINE, 10'h000, 8'h00);
        send_item(ACT_SPARE_HI, 10'h3FF, 8'hFF);
        // Outside the read-write mode writes are dropped and reads return the
        // address high byte unless mode bit 1 is set.
        set_exram_mode(MODE_NAMETABLE);
        send_item(ACT_WR_EXRAM, 10'h100, 8'h11);
        send_item(ACT_RD_EXRAM, 10'h100, 8'h00);
        send_item(ACT_RD_EXRAM, 10'h2FF, 8'h00);
        set_exram_mode(MODE_READ_ONLY);
        send_item(ACT_WR_EXRAM, 10'h3FF, 8'h00);
        send_item(ACT_RD_EXRAM, 10'h3FF, 8'h00);
        set_exram_mode(MODE_ATTRIBUTE);
        send_item(ACT_RD_EXRAM, 10'h3FF, 8'h00);

        // Random part, one phase per mode setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_exram_mode(phase_mode[p]);
            if (p == 0) begin
                run_counter_wrap();
            end
            run_random_phase(PHASE_ITEMS);
        end

        drain_replies();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
